// File: hdl/ldrlux_pkg.sv
package ldrlux_pkg;

    localparam int ADC_BITS_DEF = 12;

    localparam int RES_W   = 16;
    localparam int REFL_W  = 10;
    localparam int LUX_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int RND_SHIFT = 24;

    localparam logic [RES_W-1:0]  RS_RESET   = 16'd10000;
    localparam logic [RES_W-1:0]  RF_RESET   = 16'd10000;
    localparam logic [REFL_W-1:0] REFL_RESET = 10'd10;
    localparam logic              HWB_RESET  = 1'b0;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HWB  = 2'd3;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

endpackage

// File: hdl/ldrlux_alu.sv
module ldrlux_alu #(
    parameter int W = 64
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         op,
    output logic [W-1:0] sum,
    output logic         cout
);

    logic [W-1:0] b_eff;
    logic         sub;

    assign sub   = (op == ldrlux_pkg::ALU_SUB);
    assign b_eff = b ^ {W{sub}};
    // for subtract, cout high means a >= b
    assign {cout, sum} = {1'b0, a} + {1'b0, b_eff} + (W+1)'(sub);

endmodule

// File: hdl/photoresistor_adc_to_lux_top.sv
// Photoresistor divider sample to lux. Each beat on s_axis carries one converter
// sample; one beat with the lux value follows on m_axis. A single shared add/subtract
// unit does all the work bit by bit under a sequencer: two shift-add multiplies for the
// divider terms, a restoring divide for the Q16 ratio, a restoring square root, two
// more shift-add multiplies and a rounding add; with a zero fixed resistance it ends
// after the divider-term multiplies with an all-ones result.
// s_axis_tready is high only while the sequencer is idle; the output register lets the
// next sample in while a result still waits. Configuration is written through
// cfg_we/cfg_index/cfg_data and must only change while the block is idle.
module photoresistor_adc_to_lux_top #(
    parameter int ADC_BITS = ldrlux_pkg::ADC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [ADC_BITS-1:0] adc_sample
    input  logic [((ADC_BITS+7)/8)*8-1:0]        s_axis_tdata,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [31:0] illuminance_lux
    output logic [ldrlux_pkg::LUX_W-1:0]         m_axis_tdata,

    input  logic                                 cfg_we,
    input  logic [ldrlux_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ldrlux_pkg::RES_W-1:0]         cfg_data
);

    localparam int RES_W   = ldrlux_pkg::RES_W;
    localparam int REFL_W  = ldrlux_pkg::REFL_W;
    localparam int LUX_W   = ldrlux_pkg::LUX_W;
    localparam int NUM_W   = 2*RES_W + ADC_BITS;
    localparam int DEN_W   = RES_W + ADC_BITS;
    localparam int RATIO_W = NUM_W;
    localparam int ROOT_W  = (RATIO_W + 1) / 2;
    localparam int PROD_W  = REFL_W + RATIO_W + ROOT_W;
    localparam int UNIT_W  = PROD_W + 1;
    localparam int MPL_W   = ROOT_W;
    localparam int CNT_W   = $clog2(RATIO_W + 1);

    localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MULN = 4'd1;
    localparam logic [3:0] ST_MULD = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_SQRT = 4'd4;
    localparam logic [3:0] ST_MULA = 4'd5;
    localparam logic [3:0] ST_MULB = 4'd6;
    localparam logic [3:0] ST_RND  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [RES_W-1:0]  rs_reg;
    logic [RES_W-1:0]  rf_reg;
    logic [REFL_W-1:0] refl_reg;
    logic              hwb_reg;

    logic [3:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [UNIT_W-1:0]  acc_reg, acc_next;
    logic [UNIT_W-1:0]  mcand_reg, mcand_next;
    logic [MPL_W-1:0]   mplier_reg, mplier_next;
    logic [ADC_BITS-1:0] den_reg, den_next;
    logic [NUM_W-1:0]   n_reg, n_next;
    logic [DEN_W-1:0]   d_reg, d_next;
    logic [RATIO_W-1:0] q_reg, q_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [LUX_W-1:0]   res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    logic [LUX_W-1:0]   m_data_reg, m_data_next;

    logic [UNIT_W-1:0] alu_a, alu_b, alu_sum;
    logic              alu_op, alu_cout;

    logic [ADC_BITS-1:0] adc_in, adc_clamp, num_sel, den_sel;
    logic [UNIT_W-1:0]   acc_mul;
    logic                last;
    logic                out_room;
    logic [DEN_W:0]      div_t;
    logic [DEN_W-1:0]    div_rem;
    logic [ROOT_W+1:0]   sq_t, sq_trial, sq_rem;
    logic [UNIT_W-1:0]   rnd_shift;

    ldrlux_alu #(.W(UNIT_W)) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .op   (alu_op),
        .sum  (alu_sum),
        .cout (alu_cout)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign adc_in = s_axis_tdata[ADC_BITS-1:0];

    always_comb begin
        if (adc_in == '0) begin
            adc_clamp = ADC_BITS'(1);
        end else if (adc_in == ADC_MAX) begin
            adc_clamp = ADC_MAX - ADC_BITS'(1);
        end else begin
            adc_clamp = adc_in;
        end
        if (hwb_reg) begin
            num_sel = adc_clamp;
            den_sel = ADC_MAX - adc_clamp;
        end else begin
            num_sel = ADC_MAX - adc_clamp;
            den_sel = adc_clamp;
        end
    end

    assign last     = (cnt_reg == CNT_W'(1));
    assign out_room = !m_valid_reg || m_axis_tready;
    assign acc_mul  = mplier_reg[0] ? alu_sum : acc_reg;
    assign div_t    = {acc_reg[DEN_W-1:0], q_reg[RATIO_W-1]};
    assign div_rem  = alu_cout ? alu_sum[DEN_W-1:0] : div_t[DEN_W-1:0];
    assign sq_t     = {acc_reg[ROOT_W-1:0], mcand_reg[2*ROOT_W-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_rem   = alu_cout ? alu_sum[ROOT_W+1:0] : sq_t;
    assign rnd_shift = alu_sum >> ldrlux_pkg::RND_SHIFT;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        den_next    = den_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        q_next      = q_reg;
        root_next   = root_reg;
        res_next    = res_reg;
        alu_a       = acc_reg;
        alu_b       = mcand_reg;
        alu_op      = ldrlux_pkg::ALU_ADD;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    acc_next    = '0;
                    mcand_next  = UNIT_W'({rs_reg, {ldrlux_pkg::FRAC_W{1'b0}}});
                    mplier_next = MPL_W'(num_sel);
                    den_next    = den_sel;
                    cnt_next    = CNT_W'(ADC_BITS);
                    state_next  = ST_MULN;
                end
            end
            ST_MULN: begin
                acc_next    = acc_mul;
                mcand_next  = {mcand_reg[UNIT_W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - CNT_W'(1);
                if (last) begin
                    n_next      = acc_mul[NUM_W-1:0];
                    acc_next    = '0;
                    mcand_next  = UNIT_W'(rf_reg);
                    mplier_next = MPL_W'(den_reg);
                    cnt_next    = CNT_W'(ADC_BITS);
                    state_next  = ST_MULD;
                end
            end
            ST_MULD: begin
                acc_next    = acc_mul;
                mcand_next  = {mcand_reg[UNIT_W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - CNT_W'(1);
                if (last) begin
                    d_next   = acc_mul[DEN_W-1:0];
                    q_next   = n_reg;
                    acc_next = '0;
                    cnt_next = CNT_W'(RATIO_W);
                    if (rf_reg == '0) begin
                        res_next   = '1;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                alu_a    = UNIT_W'(div_t);
                alu_b    = UNIT_W'(d_reg);
                alu_op   = ldrlux_pkg::ALU_SUB;
                acc_next = UNIT_W'(div_rem);
                q_next   = {q_reg[RATIO_W-2:0], alu_cout};
                cnt_next = cnt_reg - CNT_W'(1);
                if (last) begin
                    mcand_next = UNIT_W'({q_reg[RATIO_W-2:0], alu_cout});
                    acc_next   = '0;
                    root_next  = '0;
                    cnt_next   = CNT_W'(ROOT_W);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                alu_a      = UNIT_W'(sq_t);
                alu_b      = UNIT_W'(sq_trial);
                alu_op     = ldrlux_pkg::ALU_SUB;
                acc_next   = UNIT_W'(sq_rem);
                root_next  = {root_reg[ROOT_W-2:0], alu_cout};
                mcand_next = {mcand_reg[UNIT_W-3:0], 2'b00};
                cnt_next   = cnt_reg - CNT_W'(1);
                if (last) begin
                    acc_next    = '0;
                    mcand_next  = UNIT_W'(q_reg);
                    mplier_next = MPL_W'(refl_reg);
                    cnt_next    = CNT_W'(REFL_W);
                    state_next  = ST_MULA;
                end
            end
            ST_MULA: begin
                acc_next    = acc_mul;
                mcand_next  = {mcand_reg[UNIT_W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - CNT_W'(1);
                if (last) begin
                    acc_next    = '0;
                    mcand_next  = acc_mul;
                    mplier_next = root_reg;
                    cnt_next    = CNT_W'(ROOT_W);
                    state_next  = ST_MULB;
                end
            end
            ST_MULB: begin
                acc_next    = acc_mul;
                mcand_next  = {mcand_reg[UNIT_W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - CNT_W'(1);
                if (last) begin
                    state_next = ST_RND;
                end
            end
            ST_RND: begin
                alu_b = UNIT_W'(1) << (ldrlux_pkg::RND_SHIFT - 1);
                if (|rnd_shift[UNIT_W-1:LUX_W]) begin
                    res_next = '1;
                end else begin
                    res_next = rnd_shift[LUX_W-1:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_room) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        if (state_reg == ST_OUT && out_room) begin
            m_valid_next = 1'b1;
            m_data_next  = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            rs_reg      <= ldrlux_pkg::RS_RESET;
            rf_reg      <= ldrlux_pkg::RF_RESET;
            refl_reg    <= ldrlux_pkg::REFL_RESET;
            hwb_reg     <= ldrlux_pkg::HWB_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    ldrlux_pkg::CFG_RS:   rs_reg   <= cfg_data;
                    ldrlux_pkg::CFG_RF:   rf_reg   <= cfg_data;
                    ldrlux_pkg::CFG_REFL: refl_reg <= cfg_data[REFL_W-1:0];
                    ldrlux_pkg::CFG_HWB:  hwb_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        den_reg    <= den_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        q_reg      <= q_next;
        root_reg   <= root_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule
